// ===== src/tst_pkg.sv =====
// Shared types, codes and a helper function for the thread slot table.
package tst_pkg;
  localparam int SLOTS = 32;
  localparam int IDX_W = 5;
  localparam int CNT_W = 6;

  localparam logic [3:0] CMD_SPAWN = 4'd0;
  localparam logic [3:0] CMD_TRANSIT = 4'd1;
  localparam logic [3:0] CMD_SET_STATE = 4'd2;
  localparam logic [3:0] CMD_WAKE = 4'd3;
  localparam logic [3:0] CMD_SET_EXIT = 4'd4;
  localparam logic [3:0] CMD_REAP = 4'd5;
  localparam logic [3:0] CMD_REAP_OWNER = 4'd6;
  localparam logic [3:0] CMD_MARK_EXITED = 4'd7;
  localparam logic [3:0] CMD_NTH = 4'd8;
  localparam logic [3:0] CMD_FIRST = 4'd9;
  localparam logic [3:0] CMD_ACTIVE = 4'd10;
  localparam logic [3:0] CMD_LOOKUP = 4'd11;

  localparam logic [2:0] ST_FREE = 3'd0;
  localparam logic [2:0] ST_NEW = 3'd1;
  localparam logic [2:0] ST_READY = 3'd2;
  localparam logic [2:0] ST_RUNNING = 3'd3;
  localparam logic [2:0] ST_BLOCKED = 3'd4;
  localparam logic [2:0] ST_ZOMBIE = 3'd5;

  // controller -> datapath
  typedef struct packed {
    logic start;   // latch command, clear scan state
    logic step;    // examine slot at scan index
    logic finish;  // apply single-slot action, form result
  } tst_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic last;    // scan index at final slot
  } tst_sts_t;

  function automatic logic edge_ok(input logic [2:0] from, input logic [2:0] to);
    logic r;
    if (to > ST_ZOMBIE) r = 1'b0;
    else if (from == to) r = 1'b1;
    else if (from == ST_ZOMBIE) r = (to == ST_FREE);
    else if (from == ST_FREE) r = (to == ST_NEW);
    else if (to == ST_FREE || to == ST_NEW) r = 1'b0;
    else if (from == ST_NEW) r = (to == ST_READY || to == ST_BLOCKED);
    else r = (from <= ST_ZOMBIE);
    return r;
  endfunction
endpackage

// ===== src/tst_ctrl.sv =====
// Sequencer: accept, scan all slots, finish, present result.
module tst_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_fire,
  input  logic               out_fire,
  input  tst_pkg::tst_sts_t  sts,
  output tst_pkg::tst_ctl_t  ctl,
  output logic               in_ready,
  output logic               out_valid
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state, state_next;

  always_comb begin
    state_next = state;
    ctl = '0;
    unique case (state)
      S_IDLE: if (in_fire) begin
        ctl.start = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        ctl.step = 1'b1;
        if (sts.last) state_next = S_FIN;
      end
      S_FIN: begin
        ctl.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: if (out_fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule

// ===== src/tst_datapath.sv =====
// Slot table storage, scan logic and result registers.
module tst_datapath (
  input  logic                     clk,
  input  logic                     rst,
  input  tst_pkg::tst_ctl_t        ctl,
  output tst_pkg::tst_sts_t        sts,
  input  logic [3:0]               cmd,
  input  logic [31:0]              thread_id,
  input  logic [31:0]              owner_id,
  input  logic [2:0]               from_state,
  input  logic [2:0]               to_state,
  input  logic [3:0]               reason_code,
  input  logic signed [31:0]       status_code,
  input  logic [7:0]               nth_index,
  output logic                     ok,
  output logic [31:0]              tid_out,
  output logic [5:0]               refused_count,
  output logic [4:0]               slot_index,
  output logic [2:0]               state_out,
  output logic                     active
);
  localparam int N = tst_pkg::SLOTS;
  localparam int IW = tst_pkg::IDX_W;

  logic [31:0] slot_tid [N];
  logic [31:0] slot_owner [N];
  logic [2:0]  slot_state [N];
  logic [3:0]  slot_reason [N];
  logic [31:0] slot_exit [N];
  logic [31:0] next_tid;

  // latched command
  logic [3:0]  c_cmd;
  logic [31:0] c_tid, c_owner, c_status;
  logic [2:0]  c_from, c_to;
  logic [3:0]  c_reason;
  logic [7:0]  c_nth;

  logic [IW-1:0] idx;
  logic          found;
  logic [IW-1:0] hit;
  logic [7:0]    cnt;
  logic [5:0]    refused;
  logic          run_seen;

  logic live, own_match, tid_match, want_tid, want_own, owner_nz;
  logic [2:0] cur;
  logic [2:0] hs;

  assign cur = slot_state[idx];
  assign live = (cur != tst_pkg::ST_FREE);
  assign owner_nz = (c_owner != 32'd0);
  assign own_match = live && owner_nz && (slot_owner[idx] == c_owner);
  assign tid_match = live && (c_tid != 32'd0) && (slot_tid[idx] == c_tid);
  assign want_tid = (c_cmd == tst_pkg::CMD_TRANSIT) || (c_cmd == tst_pkg::CMD_SET_STATE) ||
                    (c_cmd == tst_pkg::CMD_WAKE) || (c_cmd == tst_pkg::CMD_SET_EXIT) ||
                    (c_cmd == tst_pkg::CMD_REAP) || (c_cmd == tst_pkg::CMD_LOOKUP);
  assign want_own = (c_cmd == tst_pkg::CMD_NTH) || (c_cmd == tst_pkg::CMD_FIRST);
  assign sts.last = (idx == IW'(N - 1));
  assign hs = slot_state[hit];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) begin
        slot_tid[i] <= '0;
        slot_owner[i] <= '0;
        slot_state[i] <= tst_pkg::ST_FREE;
        slot_reason[i] <= '0;
        slot_exit[i] <= '0;
      end
      next_tid <= 32'd1;
      idx <= '0;
      found <= 1'b0;
      hit <= '0;
      cnt <= '0;
      refused <= '0;
      run_seen <= 1'b0;
      ok <= 1'b0; tid_out <= '0; refused_count <= '0;
      slot_index <= '0; state_out <= '0; active <= 1'b0;
    end else if (ctl.start) begin
      c_cmd <= cmd; c_tid <= thread_id; c_owner <= owner_id;
      c_from <= from_state; c_to <= to_state; c_reason <= reason_code;
      c_status <= status_code; c_nth <= nth_index;
      idx <= '0; found <= 1'b0; hit <= '0; cnt <= '0;
      refused <= '0; run_seen <= 1'b0;
    end else if (ctl.step) begin
      idx <= idx + 1'b1;
      unique case (c_cmd)
        tst_pkg::CMD_SPAWN:
          if (!found && !live) begin found <= 1'b1; hit <= idx; end
        tst_pkg::CMD_REAP_OWNER:
          if (own_match) begin
            if (cur == tst_pkg::ST_RUNNING) begin
              if (refused != 6'd63) refused <= refused + 1'b1;
            end else begin
              slot_tid[idx] <= '0; slot_owner[idx] <= '0;
              slot_state[idx] <= tst_pkg::ST_FREE;
              slot_reason[idx] <= '0; slot_exit[idx] <= '0;
            end
          end
        tst_pkg::CMD_MARK_EXITED:
          if (own_match) begin
            slot_exit[idx] <= c_status;
            slot_reason[idx] <= '0;
            if (tst_pkg::edge_ok(cur, tst_pkg::ST_ZOMBIE))
              slot_state[idx] <= tst_pkg::ST_ZOMBIE;
          end
        tst_pkg::CMD_ACTIVE:
          if (own_match && cur == tst_pkg::ST_RUNNING) run_seen <= 1'b1;
        default: begin
          if (want_tid && !found && tid_match) begin found <= 1'b1; hit <= idx; end
          if (want_own && !found && own_match) begin
            if (c_cmd == tst_pkg::CMD_FIRST || cnt == c_nth) begin
              found <= 1'b1; hit <= idx;
            end else cnt <= cnt + 1'b1;
          end
        end
      endcase
    end else if (ctl.finish) begin
      ok <= 1'b0; tid_out <= '0; refused_count <= '0;
      slot_index <= '0; state_out <= '0; active <= 1'b0;
      unique case (c_cmd)
        tst_pkg::CMD_SPAWN:
          if (owner_nz && found) begin
            next_tid <= next_tid + 32'd1;
            if (tst_pkg::edge_ok(tst_pkg::ST_NEW, c_to)) begin
              slot_tid[hit] <= next_tid; slot_owner[hit] <= c_owner;
              slot_state[hit] <= c_to; slot_reason[hit] <= c_reason;
              slot_exit[hit] <= '0;
              ok <= 1'b1; tid_out <= next_tid; slot_index <= hit; state_out <= c_to;
            end else begin
              slot_tid[hit] <= '0; slot_owner[hit] <= '0;
              slot_reason[hit] <= '0; slot_exit[hit] <= '0;
            end
          end
        tst_pkg::CMD_TRANSIT:
          if (found) begin
            tid_out <= slot_tid[hit]; slot_index <= hit; state_out <= hs;
            if (tst_pkg::edge_ok(c_from, c_to) && hs == c_from) begin
              slot_state[hit] <= c_to; ok <= 1'b1; state_out <= c_to;
            end
          end
        tst_pkg::CMD_SET_STATE:
          if (found) begin
            tid_out <= slot_tid[hit]; slot_index <= hit; state_out <= hs;
            if (tst_pkg::edge_ok(hs, c_to)) begin
              slot_state[hit] <= c_to; slot_reason[hit] <= c_reason;
              ok <= 1'b1; state_out <= c_to;
            end
          end
        tst_pkg::CMD_WAKE:
          if (found) begin
            tid_out <= slot_tid[hit]; slot_index <= hit; state_out <= hs;
            if (hs == tst_pkg::ST_BLOCKED) begin
              slot_state[hit] <= tst_pkg::ST_READY; slot_reason[hit] <= '0;
              ok <= 1'b1; state_out <= tst_pkg::ST_READY;
            end
          end
        tst_pkg::CMD_SET_EXIT:
          if (found) begin
            slot_exit[hit] <= c_status;
            ok <= 1'b1; tid_out <= slot_tid[hit]; slot_index <= hit; state_out <= hs;
          end
        tst_pkg::CMD_REAP:
          if (!found) ok <= 1'b1;
          else if (hs == tst_pkg::ST_RUNNING) begin
            refused_count <= 6'd1;
            tid_out <= slot_tid[hit]; slot_index <= hit; state_out <= hs;
          end else begin
            ok <= 1'b1; tid_out <= slot_tid[hit]; slot_index <= hit;
            slot_tid[hit] <= '0; slot_owner[hit] <= '0;
            slot_state[hit] <= tst_pkg::ST_FREE;
            slot_reason[hit] <= '0; slot_exit[hit] <= '0;
          end
        tst_pkg::CMD_REAP_OWNER:
          if (owner_nz) begin
            refused_count <= refused; ok <= (refused == 6'd0);
          end
        tst_pkg::CMD_MARK_EXITED: ok <= owner_nz;
        tst_pkg::CMD_ACTIVE: begin
          ok <= owner_nz; active <= run_seen;
        end
        tst_pkg::CMD_NTH, tst_pkg::CMD_FIRST, tst_pkg::CMD_LOOKUP:
          if (found) begin
            ok <= 1'b1; tid_out <= slot_tid[hit]; slot_index <= hit; state_out <= hs;
          end
        default: ;
      endcase
    end
  end
endmodule

// ===== src/thread_slot_table_top.sv =====
// Top level of the thread slot table: sequencer plus slot datapath.
// Usage:
//  - Input channel (in_valid/in_ready) carries one command per transfer:
//    cmd, thread_id, owner_id, from_state, to_state, reason_code,
//    status_code, nth_index.
//  - Output channel (out_valid/out_ready) returns exactly one result per
//    command: ok, tid_out, refused_count, slot_index, state_out, active.
//  - Each command walks every slot once, one slot per cycle, through the
//    single slot-read path of the datapath; then the finish state applies
//    the single-slot update and forms the result.
//  - One command is in flight at a time; in_ready is high only while the
//    block is idle.
//  - If the receiver stalls, the result holds steady in the output
//    registers and no new command is taken until it is transferred.
//  - Synchronous reset frees all slots, clears every field and sets the
//    id counter to one.
module thread_slot_table_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         cmd,
  input  logic [31:0]        thread_id,
  input  logic [31:0]        owner_id,
  input  logic [2:0]         from_state,
  input  logic [2:0]         to_state,
  input  logic [3:0]         reason_code,
  input  logic signed [31:0] status_code,
  input  logic [7:0]         nth_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               ok,
  output logic [31:0]        tid_out,
  output logic [5:0]         refused_count,
  output logic [4:0]         slot_index,
  output logic [2:0]         state_out,
  output logic               active
);
  tst_pkg::tst_ctl_t ctl;
  tst_pkg::tst_sts_t sts;

  tst_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_fire(in_valid && in_ready),
    .out_fire(out_valid && out_ready),
    .sts(sts), .ctl(ctl),
    .in_ready(in_ready), .out_valid(out_valid)
  );

  tst_datapath u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .sts(sts),
    .cmd(cmd), .thread_id(thread_id), .owner_id(owner_id),
    .from_state(from_state), .to_state(to_state), .reason_code(reason_code),
    .status_code(status_code), .nth_index(nth_index),
    .ok(ok), .tid_out(tid_out), .refused_count(refused_count),
    .slot_index(slot_index), .state_out(state_out), .active(active)
  );
endmodule
